// ===== rtl/itrd_pkg.sv =====
`default_nettype none
package itrd_pkg;

    // Fixed widths of the beat fields
    localparam int VALUE_W = 64;
    localparam int RADIX_W = 5;
    localparam int CHAR_W  = 7;
    localparam int COUNT_W = 7;
    localparam int DIGIT_W = 4;

    // Default store depth
    localparam int MAX_DIGITS_DEF = 64;

    // Bits of the magnitude consumed by the divider in one cycle
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = VALUE_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Legal base range
    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

    // ASCII codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] ASCII_UPPER = CHAR_W'(8'h37); // 'A' - 10
    localparam logic [CHAR_W-1:0] ASCII_LOWER = CHAR_W'(8'h57); // 'a' - 10

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a new input beat
        logic div_step;   // run one divider cycle
        logic div_commit; // last divider cycle: store the digit
        logic rd;         // read the digit store
        logic out_load;   // move the read digit into the output register
    } itrd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic conv_end;   // on commit: no further digit to produce
        logic out_free;   // output register can take a beat
        logic idx_zero;   // read pointer sits on the least significant digit
    } itrd_status_t;

    // Map one digit to its ASCII code
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                        input logic lower);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        if (d < DIGIT_W'(10)) begin
            return ASCII_ZERO + dx;
        end else if (lower) begin
            return ASCII_LOWER + dx;
        end else begin
            return ASCII_UPPER + dx;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/itrd_ctrl.sv =====
`default_nettype none
module itrd_ctrl
    import itrd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output itrd_cmd_t         cmd,
    input  wire itrd_status_t status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_SHOW
    } state_t;

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic last_step;

    assign last_step = (step_reg == STEP_W'(DIV_STEPS - 1));

    // Decode commands and next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (last_step) begin
                    cmd.div_commit = 1'b1;
                    if (status.conv_end) begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_SHOW;
            end
            S_SHOW: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = status.idx_zero ? S_IDLE : S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/itrd_dp.sv =====
`default_nettype none
module itrd_dp
    import itrd_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire itrd_cmd_t                  cmd,
    output itrd_status_t                    status,
    input  wire logic signed [VALUE_W-1:0]  s_value,
    input  wire logic        [RADIX_W-1:0]  s_radix,
    input  wire logic                       s_lowercase,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic             [CHAR_W-1:0]   m_ascii_char,
    output logic             [COUNT_W-1:0]  m_digit_count,
    output logic                            m_last
);

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] rd_data_reg;

    logic [VALUE_W-1:0] mag_reg;
    logic [RADIX_W-1:0] base_reg;
    logic               lower_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [CNT_W-1:0]   held_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               last_reg;

    logic [VALUE_W-1:0] abs_value;
    logic [RADIX_W-1:0] base_clamped;
    logic [DIV_BITS-1:0] q_byte;
    logic [DIGIT_W-1:0] rem_next;
    logic [VALUE_W-1:0] mag_next;
    logic [CNT_W-1:0]   held_inc;

    // Magnitude of the two's complement input
    assign abs_value = s_value[VALUE_W-1] ? (~VALUE_W'(s_value) + VALUE_W'(1))
                                          : VALUE_W'(s_value);

    // Clamp the base into two to sixteen
    always_comb begin
        if (s_radix < RADIX_MIN) begin
            base_clamped = RADIX_MIN;
        end else if (s_radix > RADIX_MAX) begin
            base_clamped = RADIX_MAX;
        end else begin
            base_clamped = s_radix;
        end
    end

    // Restoring division over the top byte of the magnitude
    always_comb begin
        logic [DIGIT_W-1:0] r;
        logic [DIGIT_W:0]   t;
        r = rem_reg;
        q_byte = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {r, mag_reg[VALUE_W-1-i]};
            if (t >= base_reg) begin
                q_byte[DIV_BITS-1-i] = 1'b1;
                r = DIGIT_W'(t - base_reg);
            end else begin
                r = t[DIGIT_W-1:0];
            end
        end
        rem_next = r;
    end

    assign mag_next = {mag_reg[VALUE_W-DIV_BITS-1:0], q_byte};
    assign held_inc = held_reg + CNT_W'(1);

    assign status.conv_end = (mag_next == '0) || (held_inc == CNT_W'(MAX_DIGITS));
    assign status.out_free = !out_valid_reg || m_ready;
    assign status.idx_zero = (idx_reg == '0);

    // Conversion registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            mag_reg  <= '0;
        end else begin
            if (cmd.load) begin
                mag_reg   <= abs_value;
                base_reg  <= base_clamped;
                lower_reg <= s_lowercase;
                rem_reg   <= '0;
                held_reg  <= '0;
            end else if (cmd.div_step) begin
                mag_reg <= mag_next;
                if (cmd.div_commit) begin
                    rem_reg  <= '0;
                    held_reg <= held_inc;
                    idx_reg  <= held_reg[IDX_W-1:0];
                end else begin
                    rem_reg <= rem_next;
                end
            end else if (cmd.out_load && idx_reg != '0) begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
        end
    end

    // Digit store, least significant digit at entry zero
    always_ff @(posedge aclk) begin
        if (cmd.div_commit) begin
            digit_mem[held_reg[IDX_W-1:0]] <= rem_next;
        end
        if (cmd.rd) begin
            rd_data_reg <= digit_mem[idx_reg];
        end
    end

    // Output register: load a beat, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            char_reg  <= digit_to_ascii(rd_data_reg, lower_reg);
            count_reg <= COUNT_W'(held_reg);
            last_reg  <= (idx_reg == '0);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_ascii_char  = char_reg;
    assign m_digit_count = count_reg;
    assign m_last        = last_reg;

endmodule
`default_nettype wire

// ===== rtl/integer_to_radix_digits.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_value, s_radix, s_lowercase
// m_        out        m_valid/m_ready    m_ascii_char, m_digit_count, m_last
//
// Each digit of a value takes one pass of the restoring divider over the
// magnitude (8 quotient bits per cycle); the digits are then emitted, each by a
// read of the digit store followed by a load of the output register.
// Reset is synchronous, active low; the digit store needs no clearing.
// A stalled m_ready holds the current digit; the last digit may wait while
// the next value is taken in.
`default_nettype none
module integer_to_radix_digits
    import itrd_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [VALUE_W-1:0]  s_value,
    input  wire logic        [RADIX_W-1:0]  s_radix,
    input  wire logic                       s_lowercase,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic             [CHAR_W-1:0]   m_ascii_char,
    output logic             [COUNT_W-1:0]  m_digit_count,
    output logic                            m_last
);

    itrd_cmd_t    cmd;
    itrd_status_t status;

    itrd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    itrd_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_value       (s_value),
        .s_radix       (s_radix),
        .s_lowercase   (s_lowercase),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ascii_char  (m_ascii_char),
        .m_digit_count (m_digit_count),
        .m_last        (m_last)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a conversion is running");

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten before its beat was taken");

    a_commit_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_commit |-> cmd.div_step)
        else $error("digit committed outside a divider cycle");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_digit_count != '0)
        else $error("digit beat with zero digit count");
`endif

endmodule
`default_nettype wire
